@@ src/asc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_pkg: shared types and constants of the allele strand read counter
// Item and result payload types, action, base and status codes, the work
// codes passed from the classifier to the counter bank, and register resets.
// ----------------------------------------------------------------------------
package asc_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 24;
  localparam int RESULT_WIDTH        = 24;
  localparam int NUM_COUNTERS        = 6;

  // Longest aligned base string that is accepted; longer reads are a range fault.
  localparam logic [10:0] MAX_READ_LEN = 11'd1024;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Item actions.
  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  // Base codes.
  localparam logic [2:0] BASE_T   = 3'd3;
  localparam logic [2:0] BASE_N   = 3'd4;
  localparam logic [2:0] BASE_GAP = 3'd5;

  localparam logic [3:0] ALLELE_MISSING = 4'd15;

  // Status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_BAD_BASE  = 2'd2;
  localparam logic [1:0] STATUS_NO_TAG    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_FIVE_CUT  = 2'd0;
  localparam logic [1:0] REG_THREE_CUT = 2'd1;
  localparam logic [1:0] REG_REF_LIMIT = 2'd2;
  localparam logic [1:0] REG_ALT_LIMIT = 2'd3;

  localparam logic [9:0]  FIVE_CUT_RESET  = 10'd2;
  localparam logic [9:0]  THREE_CUT_RESET = 10'd2;
  localparam logic [15:0] REF_LIMIT_RESET = 16'd10;
  localparam logic [15:0] ALT_LIMIT_RESET = 16'd11;

  // Work codes for the counter bank.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_BUMP  = 2'd1;
  localparam logic [1:0] OP_EMIT  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [2:0]         base_code;
    logic [1:0]         alt_base;
    logic [3:0]         first_allele;
    logic [3:0]         second_allele;
    logic               is_phased;
    logic               reverse_strand;
    logic signed [11:0] base_position;
    logic [10:0]        aligned_length;
    logic [1:0]         tag_flags;
    logic [15:0]        lower_tag_count;
    logic [15:0]        upper_tag_count;
  } item_t;

  typedef struct packed {
    logic [RESULT_WIDTH-1:0] hap_one_plus;
    logic [RESULT_WIDTH-1:0] hap_one_minus;
    logic [RESULT_WIDTH-1:0] hap_two_plus;
    logic [RESULT_WIDTH-1:0] hap_two_minus;
    logic [RESULT_WIDTH-1:0] other_plus;
    logic [RESULT_WIDTH-1:0] other_minus;
    logic [1:0]              status;
  } result_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] slot;
    logic [1:0] status;
  } op_t;

endpackage

@@ src/asc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_front: item classifier
// Holds the site description, the sticky error and the filter registers,
// decides the fate of every item combinationally and queues work for the
// counter bank.
// ----------------------------------------------------------------------------
module asc_front import asc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  input  logic        full,
  output logic        push,
  output op_t         push_op
);

  logic [9:0]  five_cut;
  logic [9:0]  three_cut;
  logic [15:0] ref_limit;
  logic [15:0] alt_limit;

  logic [1:0]  site_ref;
  logic [1:0]  site_alt;
  logic [3:0]  allele_one;
  logic [3:0]  allele_two;
  logic        phased;
  logic        missing;
  logic [1:0]  error_code;

  logic        accept;
  logic        pos_bad;
  logic        len_over;
  logic [10:0] pos_low;
  logic [10:0] tail_dist;
  logic [10:0] five_dist;
  logic [10:0] three_dist;
  logic        cut_skip;
  logic        is_ref;
  logic        is_alt;
  logic        tag_skip;
  logic        read_fault;
  logic [1:0]  fault_code;
  logic        read_bump;
  logic [1:0]  want;
  logic        hap;
  logic [2:0]  slot;

  assign item_stall = full;
  assign accept     = item_valid && !full;

  assign pos_low   = item.base_position[10:0];
  assign pos_bad   = item.base_position[11] || ({1'b0, pos_low} >= {1'b0, item.aligned_length});
  assign len_over  = item.aligned_length > MAX_READ_LEN;
  assign tail_dist = item.aligned_length - pos_low;
  assign five_dist  = item.reverse_strand ? tail_dist : pos_low;
  assign three_dist = item.reverse_strand ? pos_low : tail_dist;
  assign cut_skip  = (five_dist <= {1'b0, five_cut}) || (three_dist <= {1'b0, three_cut});

  assign is_ref = (item.base_code <= BASE_T) && (item.base_code[1:0] == site_ref);
  assign is_alt = !is_ref && (item.base_code <= BASE_T) && (item.base_code[1:0] == site_alt);

  // Reference reads test the upper-case tag against the alt limit.
  assign tag_skip =
      (is_ref && item.tag_flags[0] && (item.lower_tag_count > ref_limit)) ||
      (is_ref && item.tag_flags[1] && (item.upper_tag_count > alt_limit)) ||
      (is_alt && item.tag_flags[0] && (item.lower_tag_count > alt_limit)) ||
      (is_alt && item.tag_flags[1] && (item.upper_tag_count > alt_limit));

  always_comb begin
    read_fault = 1'b0;
    fault_code = STATUS_OK;
    read_bump  = 1'b0;
    if (!missing && error_code == STATUS_OK) begin
      if (pos_bad || len_over) begin
        read_fault = 1'b1;
        fault_code = STATUS_RANGE;
      end else if (cut_skip) begin
        read_bump = 1'b0;
      end else if (item.base_code == BASE_N || item.base_code == BASE_GAP) begin
        read_bump = 1'b0;
      end else if (item.base_code > BASE_T) begin
        read_fault = 1'b1;
        fault_code = STATUS_BAD_BASE;
      end else if (tag_skip) begin
        read_bump = 1'b0;
      end else if (item.tag_flags == 2'b00) begin
        read_fault = 1'b1;
        fault_code = STATUS_NO_TAG;
      end else begin
        read_bump = 1'b1;
      end
    end
  end

  // A phased heterozygous genotype places the read by allele number.
  always_comb begin
    want = is_ref ? 2'd0 : 2'd1;
    hap  = !is_ref;
    if ((allele_one != allele_two) && phased) begin
      if (allele_one == {2'b00, want}) begin
        hap = 1'b0;
      end else if (allele_two == {2'b00, want}) begin
        hap = 1'b1;
      end
    end
    slot = (is_ref || is_alt) ? {1'b0, hap, item.reverse_strand}
                              : {2'b10, item.reverse_strand};
  end

  always_comb begin
    push           = 1'b0;
    push_op.kind   = OP_BUMP;
    push_op.slot   = slot;
    push_op.status = error_code;
    unique case (item.action)
      ACT_BEGIN: begin
        push         = accept;
        push_op.kind = OP_CLEAR;
      end
      ACT_READ: begin
        push         = accept && read_bump;
        push_op.kind = OP_BUMP;
      end
      ACT_END: begin
        push         = accept;
        push_op.kind = OP_EMIT;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      five_cut  <= FIVE_CUT_RESET;
      three_cut <= THREE_CUT_RESET;
      ref_limit <= REF_LIMIT_RESET;
      alt_limit <= ALT_LIMIT_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_FIVE_CUT:  five_cut  <= cfg_data[9:0];
        REG_THREE_CUT: three_cut <= cfg_data[9:0];
        REG_REF_LIMIT: ref_limit <= cfg_data;
        REG_ALT_LIMIT: alt_limit <= cfg_data;
        default:       five_cut  <= five_cut;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      site_ref   <= 2'd0;
      site_alt   <= 2'd0;
      allele_one <= 4'd0;
      allele_two <= 4'd0;
      phased     <= 1'b0;
      missing    <= 1'b0;
      error_code <= STATUS_OK;
    end else if (accept) begin
      if (item.action == ACT_BEGIN) begin
        site_ref   <= item.base_code[1:0];
        site_alt   <= item.alt_base;
        allele_one <= item.first_allele;
        allele_two <= item.second_allele;
        phased     <= item.is_phased;
        missing    <= (item.first_allele == ALLELE_MISSING) ||
                      (item.second_allele == ALLELE_MISSING) ||
                      (item.base_code > BASE_T);
        error_code <= STATUS_OK;
      end else if (item.action == ACT_READ && read_fault) begin
        error_code <= fault_code;
      end
    end
  end

endmodule

@@ src/asc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_queue: work queue
// A short first-in first-out buffer of work codes between the classifier
// and the counter bank, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module asc_queue import asc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head,
  output logic empty,
  output logic full
);

  op_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == QUEUE_CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("work queue holds more entries than its depth");

  assert property (@(posedge clk) disable iff (rst)
      push && !pop |=> count == $past(count) + 1'b1)
    else $error("work queue lost a pushed entry");

endmodule

@@ src/asc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_back: counter bank
// Carries out queued work: clears the six saturating counters, bumps one,
// or loads them with the status into the result register.
// ----------------------------------------------------------------------------
module asc_back import asc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  op_t     head,
  input  logic    empty,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic [COUNT_WIDTH-1:0] cnt [NUM_COUNTERS];
  logic                   out_free;
  logic                   do_clear;
  logic                   do_bump;
  logic                   do_emit;

  // The result register may be reloaded in the cycle its transfer completes.
  assign out_free = !result_valid || !result_stall;
  assign pop      = !empty && ((head.kind != OP_EMIT) || out_free);
  assign do_clear = pop && (head.kind == OP_CLEAR);
  assign do_bump  = pop && (head.kind == OP_BUMP);
  assign do_emit  = pop && (head.kind == OP_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_COUNTERS; k++) begin
        cnt[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_COUNTERS; k++) begin
        if (do_clear) begin
          cnt[k] <= '0;
        end else if (do_bump && head.slot == 3'(k) && cnt[k] != '1) begin
          cnt[k] <= cnt[k] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (do_emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      result.hap_one_plus  <= RESULT_WIDTH'(cnt[0]);
      result.hap_one_minus <= RESULT_WIDTH'(cnt[1]);
      result.hap_two_plus  <= RESULT_WIDTH'(cnt[2]);
      result.hap_two_minus <= RESULT_WIDTH'(cnt[3]);
      result.other_plus    <= RESULT_WIDTH'(cnt[4]);
      result.other_minus   <= RESULT_WIDTH'(cnt[5]);
      result.status        <= head.status;
    end
  end

  assert property (@(posedge clk) disable iff (rst) do_emit |=> result_valid)
    else $error("emitted counts did not reach the result register");

  assert property (@(posedge clk) disable iff (rst)
      do_clear |=> cnt[0] == '0 && cnt[1] == '0 && cnt[2] == '0 &&
                   cnt[3] == '0 && cnt[4] == '0 && cnt[5] == '0)
    else $error("counters not cleared at site begin");

endmodule

@@ src/allele_strand_read_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allele_strand_read_counter: per-site allele and strand read counter
// Classifies site, read and end items and keeps six saturating counts per
// variant site, emitting them with a status at each end item.
// ----------------------------------------------------------------------------
// Items are accepted at one per cycle while the queue is not full. The
// classifier settles each item in the cycle it is accepted and passes work
// through a four-entry queue to the counter bank, which also completes one
// work code per cycle unless an end item waits on a stalled output. An end
// item is loaded into the result register at the edge where it leaves the
// queue, after its code has been registered in a queue entry. The input
// stalls only when the queue is full, which happens when end results wait
// on a stalled output. After reset the block is ready at once, and
// configuration registers may be written whenever no item is in flight.
module allele_strand_read_counter import asc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  logic push;
  op_t  push_op;
  logic pop;
  op_t  head;
  logic empty;
  logic full;

  asc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .full         (full),
    .push         (push),
    .push_op      (push_op)
  );

  asc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  asc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the allele strand read counter
// Drives site, read and end items with random idling on both sides, keeps
// its own model of the six per-site counters and the sticky status, and
// compares every emitted result field by field across several register
// settings.
// ----------------------------------------------------------------------------
module testbench;
  import asc_pkg::*;

  localparam logic [2:0] BASE_A     = 3'd0;
  localparam logic [2:0] BASE_C     = 3'd1;
  localparam logic [2:0] BASE_G     = 3'd2;
  localparam logic [2:0] BASE_OTHER = 3'd6;

  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam int LOWER_TAG = 0;
  localparam int UPPER_TAG = 1;
  localparam logic [1:0] TAGS_NONE      = 2'd0;
  localparam logic [1:0] TAG_LOWER_ONLY = 2'd1;
  localparam logic [1:0] TAG_UPPER_ONLY = 2'd2;
  localparam logic [1:0] TAGS_BOTH      = 2'd3;

  localparam logic [3:0] REF_ALLELE = 4'd0;
  localparam logic [3:0] ALT_ALLELE = 4'd1;

  localparam logic [RESULT_WIDTH-1:0] COUNT_MAX = '1;

  localparam int SETTLE_CYCLES    = 12;
  localparam int NUM_PHASES       = 8;
  localparam int RANDOM_PER_PHASE = 244;
  localparam int TIMEOUT_NS       = 5_000_000;

  class read_count_board;
    logic [9:0]              five_cut, three_cut;
    logic [15:0]             ref_limit, alt_limit;
    logic [RESULT_WIDTH-1:0] counts [NUM_COUNTERS];
    logic [1:0]              site_ref, site_alt;
    logic [3:0]              allele_one, allele_two;
    bit                      phased, missing;
    logic [1:0]              fault;
    result_t                 owed [$];
    int                      errors;

    function void reset_state();
      five_cut  = FIVE_CUT_RESET;
      three_cut = THREE_CUT_RESET;
      ref_limit = REF_LIMIT_RESET;
      alt_limit = ALT_LIMIT_RESET;
      foreach (counts[k]) counts[k] = '0;
      site_ref   = '0;
      site_alt   = '0;
      allele_one = '0;
      allele_two = '0;
      phased     = 1'b0;
      missing    = 1'b0;
      fault      = STATUS_OK;
      owed.delete();
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_FIVE_CUT:  five_cut  = val[9:0];
        REG_THREE_CUT: three_cut = val[9:0];
        REG_REF_LIMIT: ref_limit = val;
        REG_ALT_LIMIT: alt_limit = val;
        default: ;
      endcase
    endfunction

    // Updates the site state for one accepted transfer and queues the
    // counts that an end item must return.
    function void note_item(item_t it);
      int         pos, len, five, three, slot;
      bit         is_ref, is_alt;
      logic [3:0] want;
      result_t    r;
      case (it.action)
        ACT_BEGIN: begin
          foreach (counts[k]) counts[k] = '0;
          site_ref   = it.base_code[1:0];
          site_alt   = it.alt_base;
          allele_one = it.first_allele;
          allele_two = it.second_allele;
          phased     = it.is_phased;
          missing    = it.first_allele == ALLELE_MISSING ||
                       it.second_allele == ALLELE_MISSING || it.base_code > BASE_T;
          fault      = STATUS_OK;
        end
        ACT_END: begin
          r.hap_one_plus  = counts[0];
          r.hap_one_minus = counts[1];
          r.hap_two_plus  = counts[2];
          r.hap_two_minus = counts[3];
          r.other_plus    = counts[4];
          r.other_minus   = counts[5];
          r.status        = fault;
          owed.push_back(r);
        end
        ACT_READ: begin
          // Once a fault is held the counts stay frozen, so the first fault wins.
          if (missing || fault != STATUS_OK) return;
          pos = $signed(it.base_position);
          len = int'(it.aligned_length);
          if (pos < 0 || pos >= len || len > int'(MAX_READ_LEN)) begin
            fault = STATUS_RANGE;
            return;
          end
          five  = it.reverse_strand ? len - pos : pos;
          three = it.reverse_strand ? pos : len - pos;
          if (five <= int'(five_cut) || three <= int'(three_cut)) return;
          if (it.base_code == BASE_N || it.base_code == BASE_GAP) return;
          if (it.base_code > BASE_T) begin
            fault = STATUS_BAD_BASE;
            return;
          end
          is_ref = it.base_code[1:0] == site_ref;
          is_alt = !is_ref && it.base_code[1:0] == site_alt;
          // The upper-case tag of a reference read is held to the alt limit.
          if ((is_ref && it.tag_flags[LOWER_TAG] && it.lower_tag_count > ref_limit) ||
              (is_ref && it.tag_flags[UPPER_TAG] && it.upper_tag_count > alt_limit) ||
              (is_alt && it.tag_flags[LOWER_TAG] && it.lower_tag_count > alt_limit) ||
              (is_alt && it.tag_flags[UPPER_TAG] && it.upper_tag_count > alt_limit))
            return;
          if (it.tag_flags == TAGS_NONE) begin
            fault = STATUS_NO_TAG;
            return;
          end
          if (is_ref || is_alt) begin
            want = is_ref ? REF_ALLELE : ALT_ALLELE;
            slot = is_ref ? 0 : 2;
            if (allele_one != allele_two && phased) begin
              if (allele_one == want) slot = 0;
              else if (allele_two == want) slot = 2;
            end
          end else begin
            slot = 4;
          end
          slot += int'(it.reverse_strand);
          if (counts[slot] != COUNT_MAX) counts[slot]++;
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("%0t: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [RESULT_WIDTH-1:0] got,
                       logic [RESULT_WIDTH-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (owed.size() == 0) begin
        report_mismatch("result transfer with no end item outstanding");
        return;
      end
      want = owed.pop_front();
      compare_field("hap_one_plus", got.hap_one_plus, want.hap_one_plus);
      compare_field("hap_one_minus", got.hap_one_minus, want.hap_one_minus);
      compare_field("hap_two_plus", got.hap_two_plus, want.hap_two_plus);
      compare_field("hap_two_minus", got.hap_two_minus, want.hap_two_minus);
      compare_field("other_plus", got.other_plus, want.other_plus);
      compare_field("other_minus", got.other_minus, want.other_minus);
      compare_field("status", RESULT_WIDTH'(got.status), RESULT_WIDTH'(want.status));
    endtask
  endclass

  logic        clk;
  logic        rst          = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [1:0]  cfg_index    = '0;
  logic [15:0] cfg_data     = '0;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  item_t       item         = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;

  read_count_board sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int sent_items    = 0;

  allele_strand_read_counter uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= $urandom_range(0, 99) < stall_pct;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void set_idle_mode(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 55; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 55; end
      default: begin send_idle_pct = 35; stall_pct = 35; end
    endcase
  endfunction

  function automatic item_t any_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t site_item(logic [2:0] ref_base, logic [1:0] alt,
                                      logic [3:0] a1, logic [3:0] a2, bit ph);
    item_t it;
    it = any_item();
    it.action        = ACT_BEGIN;
    it.base_code     = ref_base;
    it.alt_base      = alt;
    it.first_allele  = a1;
    it.second_allele = a2;
    it.is_phased     = ph;
    return it;
  endfunction

  function automatic item_t read_item(logic [2:0] base, bit rev, int pos, int len,
                                      logic [1:0] flags, logic [15:0] lower,
                                      logic [15:0] upper);
    item_t it;
    it = any_item();
    it.action          = ACT_READ;
    it.base_code       = base;
    it.reverse_strand  = rev;
    it.base_position   = 12'(pos);
    it.aligned_length  = 11'(len);
    it.tag_flags       = flags;
    it.lower_tag_count = lower;
    it.upper_tag_count = upper;
    return it;
  endfunction

  function automatic item_t end_item();
    item_t it;
    it = any_item();
    it.action = ACT_END;
    return it;
  endfunction

  function automatic logic [3:0] pick_allele();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return ALLELE_MISSING;
    if (r <= 3) return 4'($urandom_range(2, 14));
    return 4'($urandom_range(0, 1));
  endfunction

  // Tag counts cluster around the limit so that both sides of each test are hit.
  function automatic logic [15:0] near_limit(logic [15:0] lim);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return lim;
      2: return (lim == 16'hFFFF) ? lim : lim + 16'd1;
      3: return (lim == 16'd0) ? lim : lim - 16'd1;
      7: return 16'($urandom);
      default: return 16'($urandom_range(0, int'(lim)));
    endcase
  endfunction

  function automatic item_t random_site();
    logic [2:0] ref_base;
    ref_base = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(4, 7))
                                             : 3'($urandom_range(0, 3));
    return site_item(ref_base, 2'($urandom), pick_allele(), pick_allele(),
                     1'($urandom));
  endfunction

  function automatic item_t random_read();
    int         len, pos, r;
    logic [2:0] base;
    logic [1:0] flags;
    r = $urandom_range(0, 19);
    if (r == 0) len = $urandom_range(1025, 2047);
    else if (r == 1) len = 1024;
    else if (r <= 13) len = $urandom_range(1, 200);
    else len = $urandom_range(1, 1024);
    r = $urandom_range(0, 39);
    if (r == 0) pos = -1;
    else if (r == 1) pos = len;
    else if (r == 2) pos = 0;
    else if (r == 3) pos = len - 1;
    else pos = $urandom_range(0, len - 1);
    r = $urandom_range(0, 39);
    if (r <= 15 || r >= 36) base = {1'b0, sb.site_ref};
    else if (r <= 27) base = {1'b0, sb.site_alt};
    else if (r <= 32) base = 3'($urandom_range(0, 3));
    else if (r == 33) base = BASE_N;
    else if (r == 34) base = BASE_GAP;
    else base = 3'($urandom_range(int'(BASE_OTHER), 7));
    flags = ($urandom_range(0, 29) == 0) ? TAGS_NONE : 2'($urandom_range(1, 3));
    return read_item(base, 1'($urandom), pos, len, flags,
                     near_limit($urandom_range(0, 1) ? sb.ref_limit : sb.alt_limit),
                     near_limit(sb.alt_limit));
  endfunction

  // Presents one item, idling first at the sender's rate, and returns at the
  // edge where the transfer takes place.
  task automatic send_item(item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
    sent_items++;
    if (sent_items % 100 == 0) set_idle_mode((sent_items / 100) % 4);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [15:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_settings(int phase);
    int cut5, cut3, lim_r, lim_a;
    case (phase)
      0: begin cut5 = 2;    cut3 = 2;    lim_r = 10;    lim_a = 11;    end
      1: begin cut5 = 0;    cut3 = 0;    lim_r = 0;     lim_a = 1;     end
      2: begin cut5 = 1023; cut3 = 1023; lim_r = 65535; lim_a = 65535; end
      3: begin cut5 = 7;    cut3 = 3;    lim_r = 5;     lim_a = 9;     end
      4: begin cut5 = 0;    cut3 = 0;    lim_r = 65535; lim_a = 1;     end
      5: begin cut5 = 1;    cut3 = 1;    lim_r = 0;     lim_a = 65535; end
      default: begin
        cut5  = $urandom_range(0, 60);
        cut3  = $urandom_range(0, 60);
        lim_r = $urandom_range(0, 40);
        lim_a = $urandom_range(1, 40);
      end
    endcase
    put_reg(REG_FIVE_CUT, 16'(cut5));
    put_reg(REG_THREE_CUT, 16'(cut3));
    put_reg(REG_REF_LIMIT, 16'(lim_r));
    put_reg(REG_ALT_LIMIT, 16'(lim_a));
    cfg_write_en <= 1'b0;
  endtask

  // Default register values apply while this list runs.
  task automatic run_directed();
    item_t plan [$];
    item_t spare;
    spare = any_item();
    spare.action = ACT_SPARE;
    // Before any site has begun the counters work on the reset state.
    plan.push_back(read_item(BASE_A, 1'b0, 5, 20, TAG_LOWER_ONLY, 16'd0, 16'd0));
    plan.push_back(end_item());
    plan.push_back(spare);
    plan.push_back(site_item(BASE_A, BASE_T[1:0], 4'd0, 4'd1, 1'b1));
    plan.push_back(read_item(BASE_A, 1'b0, 10, 100, TAGS_BOTH, 16'd10, 16'd11));
    plan.push_back(read_item(BASE_T, 1'b1, 50, 1024, TAG_UPPER_ONLY, 16'hFFFF, 16'd11));
    plan.push_back(read_item(BASE_G, 1'b0, 3, 6, TAG_LOWER_ONLY, 16'd0, 16'hFFFF));
    plan.push_back(read_item(BASE_N, 1'b0, 10, 100, TAGS_BOTH, 16'd0, 16'd0));
    plan.push_back(read_item(BASE_GAP, 1'b1, 10, 100, TAGS_BOTH, 16'd0, 16'd0));
    plan.push_back(read_item(BASE_A, 1'b0, 10, 100, TAG_LOWER_ONLY, 16'd11, 16'd0));
    plan.push_back(read_item(BASE_T, 1'b0, 10, 100, TAG_LOWER_ONLY, 16'd12, 16'd0));
    plan.push_back(read_item(BASE_A, 1'b0, 2, 100, TAGS_BOTH, 16'd0, 16'd0));
    plan.push_back(read_item(BASE_A, 1'b1, 97, 100, TAG_LOWER_ONLY, 16'd0, 16'hFFFF));
    plan.push_back(end_item());
    // Reference equal to alternate, het phased with the reference on allele two.
    plan.push_back(site_item(BASE_C, BASE_C[1:0], 4'd1, 4'd0, 1'b1));
    plan.push_back(read_item(BASE_C, 1'b1, 1000, 1024, TAGS_BOTH, 16'd0, 16'd0));
    plan.push_back(read_item(BASE_G, 1'b0, 10, 100, TAGS_NONE, 16'd0, 16'd0));
    plan.push_back(read_item(BASE_A, 1'b0, -1, 100, TAGS_BOTH, 16'd0, 16'd0));
    plan.push_back(end_item());
    plan.push_back(site_item(BASE_G, BASE_A[1:0], ALLELE_MISSING, 4'd0, 1'b0));
    plan.push_back(read_item(BASE_G, 1'b0, 10, 100, TAGS_BOTH, 16'd0, 16'd0));
    plan.push_back(end_item());
    plan.push_back(site_item(BASE_OTHER, BASE_A[1:0], 4'd0, 4'd1, 1'b0));
    plan.push_back(read_item(BASE_OTHER, 1'b0, 10, 100, TAGS_BOTH, 16'd0, 16'd0));
    plan.push_back(end_item());
    plan.push_back(site_item(BASE_G, BASE_A[1:0], 4'd1, 4'd1, 1'b0));
    plan.push_back(read_item(BASE_G, 1'b0, 5, 1025, TAGS_BOTH, 16'd0, 16'd0));
    plan.push_back(end_item());
    foreach (plan[i]) send_item(plan[i]);
  endtask

  initial begin
    int phase_start, n;
    sb.reset_state();
    set_idle_mode(0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      apply_settings(phase);
      if (phase == 0) run_directed();
      phase_start = sent_items;
      while (sent_items - phase_start < RANDOM_PER_PHASE) begin
        n = $urandom_range(0, 99);
        if (n < 10) begin
          send_item(any_item());
        end else begin
          // A few sequences carry on from the previous site without a begin.
          if (n >= 15) send_item(random_site());
          repeat ($urandom_range(0, 10)) begin
            send_item(random_read());
            if ($urandom_range(0, 29) == 0) send_item(end_item());
          end
          if ($urandom_range(0, 19) != 0) send_item(end_item());
        end
      end
      send_item(end_item());
      drain();
    end

    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
src/asc_pkg.sv
src/asc_front.sv
src/asc_queue.sv
src/asc_back.sv
src/allele_strand_read_counter.sv
tb/sv/testbench.sv
